/* hdl/c2sr_pkg.sv */
// ----------------------------------------------------------------------------
// c2sr_pkg
// Shared constants, status codes and types of the Cartesian to spherical
// rate converter.
// ----------------------------------------------------------------------------
package c2sr_pkg;

	localparam int FRAC_BITS = 16;

	localparam int XW       = 32;
	localparam int SQ_W     = 64;
	localparam int SQ_RW    = SQ_W + 2;
	localparam int SQ_STEPS = SQ_W;
	localparam int NUM_W    = 96;

	localparam int DIV_QW  = 32;
	localparam int DIV_AW  = NUM_W + FRAC_BITS + DIV_QW;
	localparam int DIV_DW  = 128;
	localparam int DIV_LAT = DIV_QW + 2;

	localparam logic REG_AXIS_MODE = 1'b0;

	localparam logic AXIS_WORLD  = 1'b0;
	localparam logic AXIS_CAMERA = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_AXIS   = 2'd1;
	localparam logic [1:0] ST_ORIGIN = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	localparam logic [XW-1:0] SAT_POS = {1'b0, {(XW-1){1'b1}}};
	localparam logic [XW-1:0] SAT_NEG = {1'b1, {(XW-1){1'b0}}};

	typedef struct packed {
		logic [DIV_QW:0] q;
		logic            ovf;
	} div_res_t;

endpackage

/* hdl/c2sr_div.sv */
// ----------------------------------------------------------------------------
// c2sr_div
// Pipelined restoring divider: one quotient bit per stage, overflow check up
// front, round half up at the end.
// ----------------------------------------------------------------------------
module c2sr_div
	import c2sr_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [DIV_AW-1:0] a,
	input  logic [DIV_DW-1:0] d,
	output div_res_t          res
);

	typedef struct packed {
		logic [DIV_DW-1:0] rem;
		logic [DIV_DW-1:0] d;
		logic [DIV_QW-1:0] lo;
		logic [DIV_QW-1:0] q;
		logic              ovf;
	} dv_t;

	dv_t      dv_s [DIV_QW+1];
	div_res_t res_s;
	logic     rnd;

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].rem <= DIV_DW'(a[DIV_AW-1:DIV_QW]);
			dv_s[0].d   <= d;
			dv_s[0].lo  <= a[DIV_QW-1:0];
			dv_s[0].q   <= '0;
			dv_s[0].ovf <= DIV_DW'(a[DIV_AW-1:DIV_QW]) >= d;
		end
	end

	for (genvar k = 1; k <= DIV_QW; k++) begin : g_step
		localparam int I = DIV_QW - k;
		logic [DIV_DW:0] cur;
		logic            dge;
		dv_t             nxt;
		assign cur = {dv_s[k-1].rem, dv_s[k-1].lo[I]};
		assign dge = cur >= {1'b0, dv_s[k-1].d};
		always_comb begin
			nxt = dv_s[k-1];
			if (dge) begin
				nxt.rem  = DIV_DW'(cur - {1'b0, dv_s[k-1].d});
				nxt.q[I] = 1'b1;
			end else begin
				nxt.rem = cur[DIV_DW-1:0];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= nxt;
			end
		end
	end

	assign rnd = {dv_s[DIV_QW].rem, 1'b0} >= {1'b0, dv_s[DIV_QW].d};

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.q   <= {1'b0, dv_s[DIV_QW].q} + (DIV_QW+1)'(rnd);
			res_s.ovf <= dv_s[DIV_QW].ovf;
		end
	end

	assign res = res_s;

endmodule

/* hdl/cartesian_to_spherical_rates_core.sv */
// ----------------------------------------------------------------------------
// cartesian_to_spherical_rates_core
// Converts target position and velocity into yaw rate, pitch rate and range
// rate, saturated, with axis and origin cases flagged in status.
//
//   Channel  Handshake             Payload
//   config   psel/penable/pready   paddr, pwdata, prdata (axis_mode)
//   request  req_valid/req_ready   pos_x..pos_z, vel_x..vel_z
//   result   res_valid/res_ready   yaw_rate, pitch_rate, range_rate, status
//
// One request per cycle unless the result buffer is full. A request passes 7
// product stages, 64 square-root stages (one root bit each), 3 multiply stages,
// 34 divider stages (overflow check, one quotient bit per step, rounding), then
// a two-entry result buffer. Reset clears valid bits, buffer and axis_mode.
// The pipeline holds only when the buffer is full; req_ready comes from a register.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_rates_core
	import c2sr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic signed [XW-1:0] pos_x,
	input  logic signed [XW-1:0] pos_y,
	input  logic signed [XW-1:0] pos_z,
	input  logic signed [XW-1:0] vel_x,
	input  logic signed [XW-1:0] vel_y,
	input  logic signed [XW-1:0] vel_z,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic signed [XW-1:0] yaw_rate,
	output logic signed [XW-1:0] pitch_rate,
	output logic signed [XW-1:0] range_rate,
	output logic [1:0]           status
);

	typedef struct packed {
		logic [63:0]      rho2;
		logic [63:0]      r2;
		logic [63:0]      cross_mag;
		logic [63:0]      dot_mag;
		logic [NUM_W-1:0] num_mag;
		logic             cross_neg;
		logic             dot_neg;
		logic             num_neg;
		logic             rho_zero;
		logic             r_zero;
	} side_t;

	typedef struct packed {
		logic [SQ_RW-1:0] rem;
		logic [SQ_W-1:0]  root;
	} sq_t;

	typedef struct packed {
		logic cross_neg;
		logic dot_neg;
		logic num_neg;
		logic rho_zero;
		logic r_zero;
	} flag_t;

	typedef struct packed {
		logic [XW-1:0] yaw;
		logic [XW-1:0] pitch;
		logic [XW-1:0] rng;
		logic [1:0]    st;
	} out_t;

	function automatic sq_t sq_step(sq_t s, logic [1:0] pair);
		logic [SQ_RW+1:0] cur;
		logic [SQ_RW+1:0] trial;
		sq_t              o;
		cur   = {s.rem, pair};
		trial = (SQ_RW+2)'({s.root, 2'b01});
		if (cur >= trial) begin
			o.rem  = SQ_RW'(cur - trial);
			o.root = {s.root[SQ_W-2:0], 1'b1};
		end else begin
			o.rem  = SQ_RW'(cur);
			o.root = {s.root[SQ_W-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [XW:0] clamp(div_res_t r, logic neg);
		logic          sat;
		logic [XW-1:0] val;
		if (neg) begin
			sat = r.ovf || (r.q > {1'b0, SAT_NEG});
			val = sat ? SAT_NEG : XW'(-r.q[XW-1:0]);
		end else begin
			sat = r.ovf || (r.q > {1'b0, SAT_POS});
			val = sat ? SAT_POS : r.q[XW-1:0];
		end
		return {sat, val};
	endfunction

	logic axis_mode_q;
	logic en;
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	out_t ob_q [2];
	logic push, pop;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_mode_q <= AXIS_WORLD;
		end else if (psel && penable && pwrite && paddr[2] == REG_AXIS_MODE) begin
			axis_mode_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_AXIS_MODE) ? 32'(axis_mode_q) : '0;

	assign en        = cnt_q != 2'd2;
	assign req_ready = en;

	// stage 1: frame select
	logic                 v_s1;
	logic signed [XW-1:0] h1_s1, h2_s1, vv_s1, h1d_s1, h2d_s1, vvd_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (axis_mode_q == AXIS_CAMERA) begin
				h1_s1  <= pos_z;
				h2_s1  <= pos_x;
				vv_s1  <= pos_y;
				h1d_s1 <= vel_z;
				h2d_s1 <= vel_x;
				vvd_s1 <= vel_y;
			end else begin
				h1_s1  <= pos_x;
				h2_s1  <= pos_y;
				vv_s1  <= pos_z;
				h1d_s1 <= vel_x;
				h2d_s1 <= vel_y;
				vvd_s1 <= vel_z;
			end
		end
	end

	// stage 2: products
	logic                 v_s2;
	logic signed [63:0]   sq1_s2, sq2_s2, sq3_s2, c1_s2, c2_s2, d1_s2, d2_s2, d3_s2;
	logic signed [XW-1:0] vv_s2, vvd_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sq1_s2 <= h1_s1 * h1_s1;
			sq2_s2 <= h2_s1 * h2_s1;
			sq3_s2 <= vv_s1 * vv_s1;
			c1_s2  <= h1_s1 * h2d_s1;
			c2_s2  <= h2_s1 * h1d_s1;
			d1_s2  <= h1_s1 * h1d_s1;
			d2_s2  <= h2_s1 * h2d_s1;
			d3_s2  <= vv_s1 * vvd_s1;
			vv_s2  <= vv_s1;
			vvd_s2 <= vvd_s1;
		end
	end

	// stage 3: sums
	logic                 v_s3;
	logic [63:0]          rho2_s3, vsq_s3;
	logic signed [64:0]   cross_s3, hh_s3;
	logic signed [63:0]   d3_s3;
	logic signed [XW-1:0] vv_s3, vvd_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rho2_s3  <= $unsigned(sq1_s2) + $unsigned(sq2_s2);
			vsq_s3   <= $unsigned(sq3_s2);
			cross_s3 <= 65'(c1_s2) - 65'(c2_s2);
			hh_s3    <= 65'(d1_s2) + 65'(d2_s2);
			d3_s3    <= d3_s2;
			vv_s3    <= vv_s2;
			vvd_s3   <= vvd_s2;
		end
	end

	// stage 4: r^2, dot product, pitch numerator partial products
	logic               v_s4;
	logic [63:0]        rho2_s4, r2_s4;
	logic signed [64:0] cross_s4, a1_s4, a0_s4, b1_s4, b0_s4;
	logic signed [65:0] dot_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			rho2_s4  <= rho2_s3;
			r2_s4    <= rho2_s3 + vsq_s3;
			cross_s4 <= cross_s3;
			dot_s4   <= 66'(hh_s3) + 66'(d3_s3);
			a1_s4    <= vvd_s3 * $signed({1'b0, rho2_s3[63:32]});
			a0_s4    <= vvd_s3 * $signed({1'b0, rho2_s3[31:0]});
			b1_s4    <= vv_s3 * $signed(hh_s3[64:32]);
			b0_s4    <= vv_s3 * $signed({1'b0, hh_s3[31:0]});
		end
	end

	// stage 5: magnitudes, partial differences
	logic               v_s5;
	side_t              sd_s5;
	logic signed [65:0] t1_s5, t0_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5.rho2      <= rho2_s4;
			sd_s5.r2        <= r2_s4;
			sd_s5.cross_mag <= cross_s4[64] ? 64'(-cross_s4) : cross_s4[63:0];
			sd_s5.dot_mag   <= dot_s4[65] ? 64'(-dot_s4) : dot_s4[63:0];
			sd_s5.num_mag   <= '0;
			sd_s5.cross_neg <= cross_s4[64];
			sd_s5.dot_neg   <= dot_s4[65];
			sd_s5.num_neg   <= 1'b0;
			sd_s5.rho_zero  <= rho2_s4 == '0;
			sd_s5.r_zero    <= r2_s4 == '0;
			t1_s5           <= 66'(a1_s4) - 66'(b1_s4);
			t0_s5           <= 66'(a0_s4) - 66'(b0_s4);
		end
	end

	// stage 6: pitch numerator
	logic               v_s6;
	side_t              sd_s6;
	logic signed [97:0] num_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s6  <= sd_s5;
			num_s6 <= (98'(t1_s5) <<< 32) + 98'(t0_s5);
		end
	end

	// stage 7: numerator magnitude
	logic  v_s7;
	side_t sd_s7;
	side_t sd7_d;

	always_comb begin
		sd7_d         = sd_s6;
		sd7_d.num_mag = num_s6[97] ? NUM_W'(-num_s6) : num_s6[NUM_W-1:0];
		sd7_d.num_neg = num_s6[97];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s7 <= sd7_d;
		end
	end

	// square roots of rho^2 * 2^64 and r^2 * 2^64, one bit per stage
	sq_t   rho_sq_s [SQ_STEPS];
	sq_t   r_sq_s   [SQ_STEPS];
	side_t sqsd_s   [SQ_STEPS];
	logic  sqv_s    [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		localparam int B = SQ_STEPS - 1 - k;
		sq_t        rho_in, r_in;
		side_t      sd_in;
		logic       v_in;
		logic [1:0] rho_pair, r_pair;

		if (k == 0) begin : g_first
			assign rho_in = '0;
			assign r_in   = '0;
			assign sd_in  = sd_s7;
			assign v_in   = v_s7;
		end else begin : g_next
			assign rho_in = rho_sq_s[k-1];
			assign r_in   = r_sq_s[k-1];
			assign sd_in  = sqsd_s[k-1];
			assign v_in   = sqv_s[k-1];
		end

		if (B >= SQ_STEPS / 2) begin : g_hi
			assign rho_pair = sd_in.rho2[2*(B-SQ_STEPS/2)+1 -: 2];
			assign r_pair   = sd_in.r2[2*(B-SQ_STEPS/2)+1 -: 2];
		end else begin : g_lo
			assign rho_pair = 2'b00;
			assign r_pair   = 2'b00;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k] <= 1'b0;
			end else if (en) begin
				sqv_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rho_sq_s[k] <= sq_step(rho_in, rho_pair);
				r_sq_s[k]   <= sq_step(r_in, r_pair);
				sqsd_s[k]   <= sd_in;
			end
		end
	end

	// stages 8-10: rho * r^2
	logic        v_s8, v_s9, v_s10;
	side_t       sd_s8, sd_s9, sd_s10;
	logic [63:0] rr_s8, rr_s9, rr_s10;
	logic [63:0] pp00_s8, pp01_s8, pp10_s8, pp11_s8;
	logic [64:0] mid_s9;
	logic [127:0] hl_s9, den_s10;
	logic [SQ_W-1:0] rho_root;

	assign rho_root = rho_sq_s[SQ_STEPS-1].root;

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s8   <= sqsd_s[SQ_STEPS-1];
			rr_s8   <= r_sq_s[SQ_STEPS-1].root;
			pp00_s8 <= rho_root[31:0] * sqsd_s[SQ_STEPS-1].r2[31:0];
			pp01_s8 <= rho_root[31:0] * sqsd_s[SQ_STEPS-1].r2[63:32];
			pp10_s8 <= rho_root[63:32] * sqsd_s[SQ_STEPS-1].r2[31:0];
			pp11_s8 <= rho_root[63:32] * sqsd_s[SQ_STEPS-1].r2[63:32];
			sd_s9   <= sd_s8;
			rr_s9   <= rr_s8;
			mid_s9  <= 65'(pp01_s8) + 65'(pp10_s8);
			hl_s9   <= {pp11_s8, pp00_s8};
			sd_s10  <= sd_s9;
			rr_s10  <= rr_s9;
			den_s10 <= hl_s9 + (128'(mid_s9) << 32);
		end
	end

	// valid bits of the fixed stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s1  <= req_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= sqv_s[SQ_STEPS-1];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// dividers
	div_res_t yaw_res, pitch_res, rng_res;

	c2sr_div u_div_yaw (
		.clk (clk),
		.en  (en),
		.a   (DIV_AW'(sd_s10.cross_mag) << FRAC_BITS),
		.d   (DIV_DW'(sd_s10.rho2)),
		.res (yaw_res)
	);

	c2sr_div u_div_pitch (
		.clk (clk),
		.en  (en),
		.a   (DIV_AW'(sd_s10.num_mag) << (FRAC_BITS + 32)),
		.d   (den_s10),
		.res (pitch_res)
	);

	c2sr_div u_div_rng (
		.clk (clk),
		.en  (en),
		.a   (DIV_AW'(sd_s10.dot_mag) << 32),
		.d   (DIV_DW'(rr_s10)),
		.res (rng_res)
	);

	flag_t fl_s  [DIV_LAT];
	logic  dvv_s [DIV_LAT];

	for (genvar k = 0; k < DIV_LAT; k++) begin : g_dly
		flag_t fl_in;
		logic  v_in;
		if (k == 0) begin : g_first
			assign fl_in = '{sd_s10.cross_neg, sd_s10.dot_neg, sd_s10.num_neg,
				sd_s10.rho_zero, sd_s10.r_zero};
			assign v_in  = v_s10;
		end else begin : g_next
			assign fl_in = fl_s[k-1];
			assign v_in  = dvv_s[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k] <= 1'b0;
			end else if (en) begin
				dvv_s[k] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				fl_s[k] <= fl_in;
			end
		end
	end

	// clamp, sign and status
	logic [XW:0] yaw_c, pitch_c, rng_c;
	flag_t       fl;
	out_t        fin;

	assign fl      = fl_s[DIV_LAT-1];
	assign yaw_c   = clamp(yaw_res, fl.cross_neg);
	assign pitch_c = clamp(pitch_res, fl.num_neg);
	assign rng_c   = clamp(rng_res, fl.dot_neg);

	always_comb begin
		if (fl.r_zero) begin
			fin = '{'0, '0, '0, ST_ORIGIN};
		end else if (fl.rho_zero) begin
			fin = '{'0, '0, rng_c[XW-1:0], ST_AXIS};
		end else begin
			fin.yaw   = yaw_c[XW-1:0];
			fin.pitch = pitch_c[XW-1:0];
			fin.rng   = rng_c[XW-1:0];
			fin.st    = (yaw_c[XW] || pitch_c[XW] || rng_c[XW]) ? ST_SAT : ST_OK;
		end
	end

	// result buffer
	assign push      = en && dvv_s[DIV_LAT-1];
	assign res_valid = cnt_q != 2'd0;
	assign pop       = res_valid && res_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ob_q[wp_q] <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign yaw_rate   = ob_q[rp_q].yaw;
	assign pitch_rate = ob_q[rp_q].pitch;
	assign range_rate = ob_q[rp_q].rng;
	assign status     = ob_q[rp_q].st;

endmodule

/* hdl/c2sr_chk.sv */
// ----------------------------------------------------------------------------
// c2sr_chk
// Port-level checks of the rate converter, bound to the top level.
// ----------------------------------------------------------------------------
module c2sr_chk
	import c2sr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pready,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic signed [XW-1:0] yaw_rate,
	input logic signed [XW-1:0] pitch_rate,
	input logic signed [XW-1:0] range_rate,
	input logic [1:0]           status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(yaw_rate) && $stable(status))
		else $error("result changed while stalled");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_ORIGIN |->
			yaw_rate == '0 && pitch_rate == '0 && range_rate == '0)
		else $error("origin result with nonzero rate");

	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_AXIS |-> yaw_rate == '0 && pitch_rate == '0)
		else $error("axis result with nonzero angular rate");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("config port not ready");

endmodule

bind cartesian_to_spherical_rates_core c2sr_chk u_c2sr_chk (.*);

/* dv/cartesian_to_spherical_rates_core_tb.sv */
// ----------------------------------------------------------------------------
// cartesian_to_spherical_rates_core_tb
// Drives position/velocity requests through the rate converter in both axis
// modes, predicts yaw, pitch and range rate with exact wide integer math and
// checks every result in order, under random idling on both channels except in the final runs.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_rates_core_tb;
	import c2sr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_WAIT  = 160;

	typedef struct {
		logic signed [XW-1:0] px, py, pz, vx, vy, vz;
	} target_t;

	typedef struct {
		logic signed [XW-1:0] yaw, pitch, range;
		logic [1:0]           st;
	} rates_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]           paddr = '0;
	logic [31:0]          pwdata = '0;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic signed [XW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [XW-1:0] vel_x = '0, vel_y = '0, vel_z = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic signed [XW-1:0] yaw_rate, pitch_rate, range_rate;
	logic [1:0]           status;

	rates_t expected_rates[$];
	logic   axis_sel = AXIS_WORLD;
	bit     no_idle = 1'b0;
	int     mismatches = 0;
	int     cycles = 0;
	int     stall_left = 0;

	cartesian_to_spherical_rates_core dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [127:0] root_floor(input logic [255:0] n);
		logic [127:0] r;
		logic [127:0] c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if ({128'd0, c} * {128'd0, c} <= n) r = c;
		end
		return r;
	endfunction

	// {saturated, value}
	function automatic logic [32:0] rounded_rate(input logic signed [255:0] num, input int sh,
			input logic [255:0] den);
		logic [255:0] m;
		logic [255:0] q;
		logic [255:0] rem;
		m = num[255] ? -num : num;
		m = m << sh;
		q = m / den;
		rem = m - q * den;
		if ((rem << 1) >= den) q = q + 1;
		if (!num[255]) begin
			if (q > 256'h7FFFFFFF) return {1'b1, SAT_POS};
			return {1'b0, q[31:0]};
		end
		if (q > 256'h80000000) return {1'b1, SAT_NEG};
		return {1'b0, -q[31:0]};
	endfunction

	function automatic rates_t predict_rates(input target_t t, input logic mode);
		logic signed [255:0] h1, h2, vv, h1d, h2d, vvd;
		logic signed [255:0] rho2, r2, dotp, crs, hh, num;
		logic [32:0]         q;
		bit                  sat;
		rates_t              o;
		if (mode == AXIS_CAMERA) begin
			h1 = t.pz; h2 = t.px; vv = t.py; h1d = t.vz; h2d = t.vx; vvd = t.vy;
		end else begin
			h1 = t.px; h2 = t.py; vv = t.pz; h1d = t.vx; h2d = t.vy; vvd = t.vz;
		end
		sat = 1'b0;
		o = '{yaw: '0, pitch: '0, range: '0, st: ST_OK};
		rho2 = h1 * h1 + h2 * h2;
		r2 = rho2 + vv * vv;
		if (r2 == 0) begin
			o.st = ST_ORIGIN;
			return o;
		end
		dotp = h1 * h1d + h2 * h2d + vv * vvd;
		q = rounded_rate(dotp, 32, {128'd0, root_floor(r2 << 64)});
		o.range = q[31:0];
		sat |= q[32];
		if (rho2 == 0) begin
			o.st = ST_AXIS;
			return o;
		end
		crs = h1 * h2d - h2 * h1d;
		hh = h1 * h1d + h2 * h2d;
		num = vvd * rho2 - vv * hh;
		q = rounded_rate(crs, FRAC_BITS, rho2);
		o.yaw = q[31:0];
		sat |= q[32];
		q = rounded_rate(num, FRAC_BITS + 32, {128'd0, root_floor(rho2 << 64)} * r2);
		o.pitch = q[31:0];
		sat |= q[32];
		o.st = sat ? ST_SAT : ST_OK;
		return o;
	endfunction

	task automatic send_target(input target_t t);
		@(negedge clk);
		pos_x = t.px; pos_y = t.py; pos_z = t.pz;
		vel_x = t.vx; vel_y = t.vy; vel_z = t.vz;
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rates.push_back(predict_rates(t, axis_sel));
	endtask

	task automatic hold_off(input int n);
		@(negedge clk);
		req_valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_paced(input target_t t);
		if (!no_idle && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 18));
		send_target(t);
	endtask

	task automatic wait_drained;
		@(negedge clk);
		req_valid = 1'b0;
		while (expected_rates.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	task automatic set_axis(input logic mode);
		wait_drained();
		apb_write(3'(REG_AXIS_MODE) << 2, {31'd0, mode});
		axis_sel = mode;
	endtask

	function automatic logic signed [XW-1:0] rand_coord;
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom;
			3:       return $urandom_range(0, 1) ? SAT_POS : SAT_NEG;
			4:       return '0;
			5:       return $signed($urandom_range(0, 255)) - 128;
			default: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
		endcase
	endfunction

	function automatic target_t rand_target;
		target_t t;
		t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord()};
		case ($urandom_range(0, 19))
			0, 1: begin
				if (axis_sel == AXIS_CAMERA) begin t.pz = '0; t.px = '0; end
				else begin t.px = '0; t.py = '0; end
			end
			2: begin t.px = '0; t.py = '0; t.pz = '0; end
			default: ;
		endcase
		return t;
	endfunction

	task automatic test_directed(input logic mode);
		localparam logic signed [XW-1:0] ONE = 32'sh0001_0000;
		set_axis(mode);
		send_paced('{'0, '0, '0, ONE, -ONE, ONE});
		send_paced('{'0, '0, ONE, ONE, ONE, -ONE});
		send_paced('{'0, -ONE, '0, '0, ONE, ONE});
		send_paced('{ONE, '0, '0, '0, '0, '0});
		send_paced('{ONE, ONE, ONE, -ONE, ONE, ONE});
		send_paced('{SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS});
		send_paced('{SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG});
		send_paced('{SAT_NEG, SAT_POS, SAT_NEG, SAT_POS, SAT_NEG, SAT_POS});
		send_paced('{32'sd1, 32'sd1, 32'sd1, SAT_POS, SAT_NEG, SAT_POS});
		send_paced('{32'sd1, '0, '0, '0, SAT_NEG, SAT_NEG});
		send_paced('{'0, '0, 32'sd1, SAT_POS, SAT_POS, SAT_NEG});
		send_paced('{-32'sd1, 32'sd3, 32'sd2, 32'sd1, -32'sd1, 32'sd5});
	endtask

	task automatic test_random(input int n);
		repeat (n) send_paced(rand_target());
	endtask

	task automatic test_ignored_register;
		wait_drained();
		apb_write(3'd4, 32'hFFFF_FFFF);
		test_random(10);
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 17);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		rates_t e;
		if (arst_n && res_valid && res_ready) begin
			if (expected_rates.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				e = expected_rates.pop_front();
				if (yaw_rate !== e.yaw || pitch_rate !== e.pitch || range_rate !== e.range
						|| status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp yaw %h pitch %h range %h st %0d, got %h %h %h %0d",
							e.yaw, e.pitch, e.range, e.st, yaw_rate, pitch_rate, range_rate,
							status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed(AXIS_WORLD);
		test_directed(AXIS_CAMERA);
		test_random(110);
		set_axis(AXIS_WORLD);
		test_random(110);
		test_ignored_register();
		set_axis(AXIS_CAMERA);
		test_random(80);
		no_idle = 1'b1;
		set_axis(AXIS_WORLD);
		test_random(60);
		set_axis(AXIS_CAMERA);
		test_random(60);
		wait_drained();
		if (mismatches == 0 && expected_rates.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
